// File: hw/rtl/rch_pkg.sv
`timescale 1ns / 1ps
// Shared types, register indexes and fixed-point helpers for the ray/capsule hit pipeline.
// No dependencies; used by rch_sqrt, rch_div and ray_capsule_hit_top.
package rch_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DIV_LAT       = 34;
    localparam int S_DATA_W      = 248;
    localparam int M_DATA_W      = 184;
    localparam int CFG_IDX_W     = 3;

    typedef logic signed [31:0] fx_t;

    localparam fx_t FX_MAX = 32'sh7fffffff;
    localparam fx_t FX_MIN = 32'sh80000000;

    typedef struct packed {
        fx_t x;
        fx_t y;
        fx_t z;
    } vec_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5
    } cfg_reg_e;

    typedef struct packed {
        vec_t base;
        vec_t ax;
        vec_t o;
        vec_t m;
        vec_t n;
        vec_t po;
        vec_t raw;
        vec_t pdn;
        vec_t hp;
        vec_t nb;
        vec_t ctr;
        vec_t v;
        vec_t hp2;
        vec_t hpf;
        vec_t num;
        vec_t p;
        vec_t nrm;
        fx_t  len;
        fx_t  rad;
        fx_t  best;
        fx_t  r2;
        fx_t  doa;
        fx_t  dd;
        fx_t  pp;
        fx_t  l2;
        fx_t  l;
        fx_t  c;
        fx_t  bb;
        fx_t  h;
        fx_t  tp;
        fx_t  t;
        fx_t  hd;
        fx_t  capd;
        fx_t  b2;
        fx_t  vv;
        fx_t  bb2;
        fx_t  c2;
        fx_t  h2;
        fx_t  t2;
        fx_t  tf;
        logic signed [32:0] b;
        logic l2pos;
        logic miss1;
        logic sph;
        logic hit1;
        logic miss2;
        logic hit;
    } item_t;

    function automatic int sqrt_lat(input int f);
        return (32 + f) / 2 + 2;
    endfunction

    function automatic fx_t sat32(input logic signed [65:0] v);
        if (v > 66'(FX_MAX)) return FX_MAX;
        if (v < 66'(FX_MIN)) return FX_MIN;
        return fx_t'(v);
    endfunction

    function automatic fx_t fadd(input fx_t a, input fx_t b);
        return sat32(66'(a) + 66'(b));
    endfunction

    function automatic fx_t fsub(input fx_t a, input fx_t b);
        return sat32(66'(a) - 66'(b));
    endfunction

    function automatic fx_t fsub33(input logic signed [32:0] a, input fx_t b);
        return sat32(66'(a) - 66'(b));
    endfunction

    function automatic fx_t fmul(input fx_t a, input fx_t b, input int f);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return sat32(66'(p >>> f));
    endfunction

    function automatic fx_t fsq33(input logic signed [32:0] a, input int f);
        logic signed [65:0] p;
        p = 66'(a) * 66'(a);
        return sat32(p >>> f);
    endfunction

    function automatic vec_t vadd(input vec_t a, input vec_t b);
        return '{x: fadd(a.x, b.x), y: fadd(a.y, b.y), z: fadd(a.z, b.z)};
    endfunction

    function automatic vec_t vsub(input vec_t a, input vec_t b);
        return '{x: fsub(a.x, b.x), y: fsub(a.y, b.y), z: fsub(a.z, b.z)};
    endfunction

    function automatic vec_t vmul(input vec_t a, input vec_t b, input int f);
        return '{x: fmul(a.x, b.x, f), y: fmul(a.y, b.y, f), z: fmul(a.z, b.z, f)};
    endfunction

    function automatic vec_t vscl(input vec_t a, input fx_t s, input int f);
        return '{x: fmul(a.x, s, f), y: fmul(a.y, s, f), z: fmul(a.z, s, f)};
    endfunction

    function automatic fx_t dot3(input vec_t m);
        return fadd(fadd(m.x, m.y), m.z);
    endfunction

    function automatic fx_t nclamp(input fx_t v, input int f);
        fx_t one;
        one = fx_t'(33'sd1 <<< f);
        if (v > one) return one;
        if (v < -one) return -one;
        return v;
    endfunction

endpackage

// File: hw/rtl/rch_delay.sv
`timescale 1ns / 1ps
// Stallable delay line with a valid lane; keeps side data aligned with long units.
// Depends on nothing.
module rch_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         in_valid,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    output logic [W-1:0] out_data
);
    logic [W-1:0] data_reg [0:DEPTH-1];
    logic         vld_reg  [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DEPTH; k++) vld_reg[k] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < DEPTH; k++) vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg[0] <= in_data;
            for (int k = 1; k < DEPTH; k++) data_reg[k] <= data_reg[k-1];
        end
    end

    assign out_valid = vld_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];
endmodule

// File: hw/rtl/rch_sqrt.sv
`timescale 1ns / 1ps
// Pipelined fixed-point square root, one result bit per stage: floor(sqrt(x << FRAC_BITS)).
// Depends on rch_pkg.
module rch_sqrt #(
    parameter int FRAC_BITS = rch_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        en,
    input  rch_pkg::fx_t x,
    output rch_pkg::fx_t root
);
    import rch_pkg::*;

    localparam int RW = (32 + FRAC_BITS) / 2;
    localparam int NW = 2 * RW;
    localparam int EW = RW + 4;

    logic [NW-1:0]   n_reg    [0:RW];
    logic [RW+1:0]   rem_reg  [0:RW];
    logic [RW-1:0]   root_reg [0:RW];
    fx_t             out_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg[0]    <= (x > 0) ? NW'({x[30:0], {FRAC_BITS{1'b0}}}) : '0;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            out_reg     <= fx_t'(32'(root_reg[RW]));
        end
    end

    for (genvar i = 0; i < RW; i++) begin : g_step
        logic [EW-1:0] rem2;
        logic [EW-1:0] trial;
        logic          ge;

        always_comb begin
            rem2  = {rem_reg[i], n_reg[i][NW-1 -: 2]};
            trial = EW'({root_reg[i], 2'b01});
            ge    = rem2 >= trial;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[i+1]    <= {n_reg[i][NW-3:0], 2'b00};
                rem_reg[i+1]  <= ge ? (RW+2)'(rem2 - trial) : (RW+2)'(rem2);
                root_reg[i+1] <= {root_reg[i][RW-2:0], ge};
            end
        end
    end

    assign root = out_reg;
endmodule

// File: hw/rtl/rch_div.sv
`timescale 1ns / 1ps
// Pipelined signed fixed-point divide, one quotient bit per stage: sat((a << FRAC_BITS) / b).
// Depends on rch_pkg; a zero divisor gives zero.
module rch_div #(
    parameter int FRAC_BITS = rch_pkg::FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         en,
    input  rch_pkg::fx_t num,
    input  rch_pkg::fx_t den,
    output rch_pkg::fx_t quo
);
    import rch_pkg::*;

    localparam int NW = 32 + FRAC_BITS;
    localparam int QW = 32;

    logic [31:0]   an;
    logic [31:0]   ad;
    logic [NW-1:0] nfull;

    logic [31:0] rem_reg  [0:QW];
    logic [31:0] lo_reg   [0:QW];
    logic [31:0] q_reg    [0:QW];
    logic [31:0] dn_reg   [0:QW];
    logic        neg_reg  [0:QW];
    logic        zero_reg [0:QW];
    logic        ovf_reg  [0:QW];
    fx_t         out_reg;

    always_comb begin
        an    = num[31] ? (32'(~num) + 32'd1) : 32'(num);
        ad    = den[31] ? (32'(~den) + 32'd1) : 32'(den);
        nfull = {an, {FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= 32'(nfull[NW-1:32]);
            lo_reg[0]   <= nfull[31:0];
            q_reg[0]    <= '0;
            dn_reg[0]   <= ad;
            neg_reg[0]  <= num[31] ^ den[31];
            zero_reg[0] <= (den == '0);
            ovf_reg[0]  <= 32'(nfull[NW-1:32]) >= ad;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [32:0] tr;
        logic        ge;

        always_comb begin
            tr = {rem_reg[k], lo_reg[k][31]};
            ge = tr >= {1'b0, dn_reg[k]};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= ge ? 32'(tr - {1'b0, dn_reg[k]}) : tr[31:0];
                lo_reg[k+1]   <= {lo_reg[k][30:0], 1'b0};
                q_reg[k+1]    <= {q_reg[k][30:0], ge};
                dn_reg[k+1]   <= dn_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                zero_reg[k+1] <= zero_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (zero_reg[QW]) begin
                out_reg <= '0;
            end else if (neg_reg[QW]) begin
                out_reg <= (ovf_reg[QW] || q_reg[QW] > 32'h80000000) ? FX_MIN
                                                                      : fx_t'(~q_reg[QW] + 32'd1);
            end else begin
                out_reg <= (ovf_reg[QW] || q_reg[QW][31]) ? FX_MAX : fx_t'(q_reg[QW]);
            end
        end
    end

    assign quo = out_reg;
endmodule

// File: hw/rtl/ray_capsule_hit_top.sv
`timescale 1ns / 1ps
// Ray versus capsule intersection pipeline, signed fixed point with saturation.
// Depends on rch_pkg, rch_delay, rch_sqrt and rch_div.
//
//  channel  | direction | transfer                  | payload
//  ---------+-----------+---------------------------+-------------------------------
//  s_       | in        | s_tvalid & s_tready       | capsule and best time (tdata)
//  m_       | out       | m_tvalid & m_tready       | hit flag (tuser), point/normal/time
//  cfg_     | in        | cfg_valid & cfg_ready     | ray origin and direction registers
//
// One request per cycle while the output is not stalled; the path holds three
// pipelined square roots and three pipelined divides in series. A stalled
// output freezes the whole pipeline, so nothing is lost or repeated. Reset
// clears valid bits and loads the ray registers with origin zero and
// direction +x; cfg_ready is always high.
module ray_capsule_hit_top #(
    parameter int FRAC_BITS = rch_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // base_x, base_y, base_z, axis_x, axis_y, axis_z, seg_length, cap_radius, best_time
    input  logic [rch_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // point_x, point_y, point_z, normal_x, normal_y, normal_z, hit_time
    output logic [rch_pkg::M_DATA_W-1:0]     m_tdata,
    // hit
    output logic [0:0]                       m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rch_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                      cfg_data
);
    import rch_pkg::*;

    localparam int NST    = 32;
    localparam int SQ_LAT = sqrt_lat(FRAC_BITS);
    localparam int IW     = $bits(item_t);

    fx_t                org_x_reg, org_y_reg, org_z_reg;
    logic signed [17:0] dir_x_reg, dir_y_reg, dir_z_reg;
    vec_t               org;
    vec_t               dirv;

    item_t st_reg  [0:NST-1];
    item_t st_next [0:NST-1];
    logic  vld_reg [0:NST-1];
    logic  vld_src [0:NST-1];
    logic  en;

    item_t d1_item, d2_item, d3_item, d4_item, d5_item, d6_item;
    logic  d1_vld, d2_vld, d3_vld, d4_vld, d5_vld, d6_vld;
    fx_t   sq1, sq2, sq3;
    fx_t   dq0, dq1, dq2, dq3, dq4, dq5, dq6;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_x_reg <= '0;
            org_y_reg <= '0;
            org_z_reg <= '0;
            dir_x_reg <= 18'(1 << FRAC_BITS);
            dir_y_reg <= '0;
            dir_z_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ORIGIN_X: org_x_reg <= fx_t'(cfg_data);
                REG_ORIGIN_Y: org_y_reg <= fx_t'(cfg_data);
                REG_ORIGIN_Z: org_z_reg <= fx_t'(cfg_data);
                REG_DIR_X:    dir_x_reg <= cfg_data[17:0];
                REG_DIR_Y:    dir_y_reg <= cfg_data[17:0];
                REG_DIR_Z:    dir_z_reg <= cfg_data[17:0];
                default: ;
            endcase
        end
    end

    assign org  = '{x: org_x_reg, y: org_y_reg, z: org_z_reg};
    assign dirv = '{x: 32'(dir_x_reg), y: 32'(dir_y_reg), z: 32'(dir_z_reg)};

    assign en       = !vld_reg[NST-1] || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NST; k++) vld_reg[k] <= 1'b0;
        end else if (en) begin
            for (int k = 0; k < NST; k++) vld_reg[k] <= vld_src[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NST; k++) st_reg[k] <= st_next[k];
        end
    end

    always_comb begin
        for (int k = 1; k < NST; k++) vld_src[k] = vld_reg[k-1];
        vld_src[0]  = s_tvalid;
        vld_src[8]  = d1_vld;
        vld_src[9]  = d2_vld;
        vld_src[14] = d3_vld;
        vld_src[15] = d4_vld;
        vld_src[27] = d5_vld;
        vld_src[31] = d6_vld;
    end

    always_comb begin
        st_next[0]        = '0;
        st_next[0].base.x = fx_t'(s_tdata[31:0]);
        st_next[0].base.y = fx_t'(s_tdata[63:32]);
        st_next[0].base.z = fx_t'(s_tdata[95:64]);
        st_next[0].ax.x   = 32'(signed'(s_tdata[113:96]));
        st_next[0].ax.y   = 32'(signed'(s_tdata[131:114]));
        st_next[0].ax.z   = 32'(signed'(s_tdata[149:132]));
        st_next[0].len    = fx_t'({1'b0, s_tdata[180:150]});
        st_next[0].rad    = fx_t'({1'b0, s_tdata[211:181]});
        st_next[0].best   = fx_t'({1'b0, s_tdata[242:212]});

        st_next[1]   = st_reg[0];
        st_next[1].o = vsub(org, st_reg[0].base);

        st_next[2]    = st_reg[1];
        st_next[2].m  = vmul(st_reg[1].o, st_reg[1].ax, FRAC_BITS);
        st_next[2].n  = vmul(dirv, st_reg[1].ax, FRAC_BITS);
        st_next[2].r2 = fmul(st_reg[1].rad, st_reg[1].rad, FRAC_BITS);

        st_next[3]     = st_reg[2];
        st_next[3].doa = dot3(st_reg[2].m);
        st_next[3].dd  = dot3(st_reg[2].n);

        st_next[4]   = st_reg[3];
        st_next[4].m = vscl(st_reg[3].ax, st_reg[3].doa, FRAC_BITS);
        st_next[4].n = vscl(st_reg[3].ax, st_reg[3].dd, FRAC_BITS);

        st_next[5]     = st_reg[4];
        st_next[5].po  = vsub(st_reg[4].o, st_reg[4].m);
        st_next[5].raw = vsub(dirv, st_reg[4].n);

        st_next[6]   = st_reg[5];
        st_next[6].m = vmul(st_reg[5].raw, st_reg[5].raw, FRAC_BITS);
        st_next[6].n = vmul(st_reg[5].po, st_reg[5].po, FRAC_BITS);

        st_next[7]       = st_reg[6];
        st_next[7].l2    = dot3(st_reg[6].m);
        st_next[7].pp    = dot3(st_reg[6].n);
        st_next[7].l2pos = dot3(st_reg[6].m) > 0;

        st_next[8]   = d1_item;
        st_next[8].l = sq1;
        st_next[8].c = fsub(d1_item.pp, d1_item.r2);

        st_next[9]     = d2_item;
        st_next[9].pdn = '{x: dq0, y: dq1, z: dq2};

        st_next[10]   = st_reg[9];
        st_next[10].m = vmul(st_reg[9].po, st_reg[9].pdn, FRAC_BITS);

        st_next[11]   = st_reg[10];
        st_next[11].b = -33'(dot3(st_reg[10].m));

        st_next[12]    = st_reg[11];
        st_next[12].bb = fsq33(st_reg[11].b, FRAC_BITS);

        st_next[13]       = st_reg[12];
        st_next[13].h     = fsub(st_reg[12].bb, st_reg[12].c);
        st_next[13].miss1 = st_next[13].h[31];

        st_next[14]    = d3_item;
        st_next[14].tp = fsub33(d3_item.b, sq2);

        st_next[15]   = d4_item;
        st_next[15].t = dq3;

        st_next[16]   = st_reg[15];
        st_next[16].m = vscl(dirv, st_reg[15].t, FRAC_BITS);
        st_next[16].n = vscl(st_reg[15].pdn, st_reg[15].tp, FRAC_BITS);

        st_next[17]    = st_reg[16];
        st_next[17].hp = vadd(st_reg[16].o, st_reg[16].m);
        st_next[17].nb = vadd(st_reg[16].po, st_reg[16].n);

        st_next[18]   = st_reg[17];
        st_next[18].m = vmul(st_reg[17].hp, st_reg[17].ax, FRAC_BITS);

        st_next[19]    = st_reg[18];
        st_next[19].hd = dot3(st_reg[18].m);

        st_next[20]      = st_reg[19];
        st_next[20].sph  = 1'b1;
        st_next[20].hit1 = 1'b0;
        st_next[20].capd = '0;
        if (st_reg[19].l2pos) begin
            if (st_reg[19].miss1) begin
                st_next[20].sph = 1'b0;
            end else if (!st_reg[19].hd[31] && st_reg[19].hd <= st_reg[19].len) begin
                st_next[20].sph  = 1'b0;
                st_next[20].hit1 = !st_reg[19].t[31] && st_reg[19].t < st_reg[19].best;
            end else begin
                st_next[20].capd = (st_reg[19].hd > 0) ? st_reg[19].len : '0;
            end
        end else begin
            st_next[20].capd = st_reg[19].dd[31] ? st_reg[19].len : '0;
        end

        st_next[21]     = st_reg[20];
        st_next[21].ctr = vscl(st_reg[20].ax, st_reg[20].capd, FRAC_BITS);

        st_next[22]   = st_reg[21];
        st_next[22].v = vsub(st_reg[21].ctr, st_reg[21].o);

        st_next[23]   = st_reg[22];
        st_next[23].m = vmul(st_reg[22].v, dirv, FRAC_BITS);
        st_next[23].n = vmul(st_reg[22].v, st_reg[22].v, FRAC_BITS);

        st_next[24]    = st_reg[23];
        st_next[24].b2 = dot3(st_reg[23].m);
        st_next[24].vv = dot3(st_reg[23].n);

        st_next[25]     = st_reg[24];
        st_next[25].bb2 = fmul(st_reg[24].b2, st_reg[24].b2, FRAC_BITS);
        st_next[25].c2  = fsub(st_reg[24].vv, st_reg[24].r2);

        st_next[26]       = st_reg[25];
        st_next[26].h2    = fsub(st_reg[25].bb2, st_reg[25].c2);
        st_next[26].miss2 = st_next[26].h2[31];

        st_next[27]    = d5_item;
        st_next[27].t2 = fsub(d5_item.b2, sq3);

        st_next[28]   = st_reg[27];
        st_next[28].m = vscl(dirv, st_reg[27].t2, FRAC_BITS);

        st_next[29]     = st_reg[28];
        st_next[29].hp2 = vadd(st_reg[28].o, st_reg[28].m);

        st_next[30] = st_reg[29];
        if (st_reg[29].sph) begin
            st_next[30].hit = !st_reg[29].miss2 && !st_reg[29].t2[31]
                              && st_reg[29].t2 < st_reg[29].best;
            st_next[30].tf  = st_reg[29].t2;
            st_next[30].hpf = st_reg[29].hp2;
            st_next[30].num = vsub(st_reg[29].hp2, st_reg[29].ctr);
        end else begin
            st_next[30].hit = st_reg[29].hit1;
            st_next[30].tf  = st_reg[29].t;
            st_next[30].hpf = st_reg[29].hp;
            st_next[30].num = st_reg[29].nb;
        end

        st_next[31] = d6_item;
        if (d6_item.hit) begin
            st_next[31].p   = vadd(d6_item.hpf, d6_item.base);
            st_next[31].nrm = '{x: nclamp(dq4, FRAC_BITS), y: nclamp(dq5, FRAC_BITS),
                                z: nclamp(dq6, FRAC_BITS)};
        end else begin
            st_next[31].p   = '0;
            st_next[31].nrm = '0;
            st_next[31].tf  = d6_item.best;
        end
    end

    rch_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_l (
        .aclk(aclk), .en(en), .x(st_reg[7].l2), .root(sq1)
    );
    rch_delay #(.W(IW), .DEPTH(SQ_LAT)) u_dly1 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(vld_reg[7]), .in_data(st_reg[7]),
        .out_valid(d1_vld), .out_data(d1_item)
    );

    rch_div #(.FRAC_BITS(FRAC_BITS)) u_div_px (
        .aclk(aclk), .en(en), .num(st_reg[8].raw.x), .den(st_reg[8].l), .quo(dq0)
    );
    rch_div #(.FRAC_BITS(FRAC_BITS)) u_div_py (
        .aclk(aclk), .en(en), .num(st_reg[8].raw.y), .den(st_reg[8].l), .quo(dq1)
    );
    rch_div #(.FRAC_BITS(FRAC_BITS)) u_div_pz (
        .aclk(aclk), .en(en), .num(st_reg[8].raw.z), .den(st_reg[8].l), .quo(dq2)
    );
    rch_delay #(.W(IW), .DEPTH(DIV_LAT)) u_dly2 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(vld_reg[8]), .in_data(st_reg[8]),
        .out_valid(d2_vld), .out_data(d2_item)
    );

    rch_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_h (
        .aclk(aclk), .en(en), .x(st_reg[13].h), .root(sq2)
    );
    rch_delay #(.W(IW), .DEPTH(SQ_LAT)) u_dly3 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(vld_reg[13]), .in_data(st_reg[13]),
        .out_valid(d3_vld), .out_data(d3_item)
    );

    rch_div #(.FRAC_BITS(FRAC_BITS)) u_div_t (
        .aclk(aclk), .en(en), .num(st_reg[14].tp), .den(st_reg[14].l), .quo(dq3)
    );
    rch_delay #(.W(IW), .DEPTH(DIV_LAT)) u_dly4 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(vld_reg[14]), .in_data(st_reg[14]),
        .out_valid(d4_vld), .out_data(d4_item)
    );

    rch_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_h2 (
        .aclk(aclk), .en(en), .x(st_reg[26].h2), .root(sq3)
    );
    rch_delay #(.W(IW), .DEPTH(SQ_LAT)) u_dly5 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(vld_reg[26]), .in_data(st_reg[26]),
        .out_valid(d5_vld), .out_data(d5_item)
    );

    rch_div #(.FRAC_BITS(FRAC_BITS)) u_div_nx (
        .aclk(aclk), .en(en), .num(st_reg[30].num.x), .den(st_reg[30].rad), .quo(dq4)
    );
    rch_div #(.FRAC_BITS(FRAC_BITS)) u_div_ny (
        .aclk(aclk), .en(en), .num(st_reg[30].num.y), .den(st_reg[30].rad), .quo(dq5)
    );
    rch_div #(.FRAC_BITS(FRAC_BITS)) u_div_nz (
        .aclk(aclk), .en(en), .num(st_reg[30].num.z), .den(st_reg[30].rad), .quo(dq6)
    );
    rch_delay #(.W(IW), .DEPTH(DIV_LAT)) u_dly6 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(vld_reg[30]), .in_data(st_reg[30]),
        .out_valid(d6_vld), .out_data(d6_item)
    );

    assign m_tvalid   = vld_reg[NST-1];
    assign m_tuser[0] = st_reg[NST-1].hit;
    assign m_tdata    = {3'b000,
                         st_reg[NST-1].tf[30:0],
                         st_reg[NST-1].nrm.z[17:0],
                         st_reg[NST-1].nrm.y[17:0],
                         st_reg[NST-1].nrm.x[17:0],
                         st_reg[NST-1].p.z,
                         st_reg[NST-1].p.y,
                         st_reg[NST-1].p.x};
endmodule
